// ===== rtl/fss_pkg.sv =====
package fss_pkg;

  // default for the longest query the block holds
  localparam int MAX_QUERY_DEF = 16;

  // query storage is two 64-bit words of eight characters each
  localparam int QUERY_SLOTS = 16;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 2;

  localparam int TEXT_POS_W  = 7;
  localparam int QPOS_W      = 5;
  localparam int RUN_W       = 5;
  localparam int SCORE_W     = 10;
  localparam int OUT_SCORE_W = 11;
  localparam int BONUS_W     = 8;

  localparam logic [SCORE_W-1:0]    SCORE_CAP  = '1;
  localparam logic [RUN_W-1:0]      RUN_CAP    = '1;
  localparam logic [TEXT_POS_W-1:0] POS_CAP    = '1;
  localparam logic [TEXT_POS_W-1:0] LEN_BONUS  = 7'd40;
  localparam logic [BONUS_W-1:0]    BONUS_BASE = 8'd1;
  localparam logic [BONUS_W-1:0]    BONUS_SEP  = 8'd8;
  localparam logic [BONUS_W-1:0]    BONUS_EARLY = 8'd3;
  localparam logic [TEXT_POS_W-1:0] EARLY_LIMIT = 7'd4;

  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUERY_LOW  = 2'd0,
    REG_QUERY_HIGH = 2'd1,
    REG_QUERY_LEN  = 2'd2
  } cfg_reg_t;

  // ascii lowering of 'A'..'Z'
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic logic is_separator(input logic [7:0] c);
    return (c == CH_SLASH) || (c == CH_UNDER) || (c == CH_DASH) || (c == CH_DOT);
  endfunction

endpackage

// ===== rtl/fuzzy_subsequence_scorer.sv =====
// channel   | ports                                   | dir | notes
// ----------+-----------------------------------------+-----+--------------------------------
// input     | in_valid in_ready in_text_byte           | in  | one text byte per request
//           | in_last_byte                             |     | marks the final byte of a text
// result    | out_valid out_ready out_match_score      | out | one request per text
//           | out_matched                              |     |
// config    | cfg_wr_en cfg_index cfg_data             | in  | 0 query low, 1 query high, 2 length
//
// one text byte per cycle, unless a final byte waits on the result register: a byte lands in
// the input register, is scored against the match state on the next cycle, and the final
// byte writes the result register and sets its valid.
// reset (synchronous, rst_n low) clears the match state, the query and both valids.
// a stalled result holds only a final byte in the input register; other bytes keep flowing.
module fuzzy_subsequence_scorer #(
  parameter int MAX_QUERY = fss_pkg::MAX_QUERY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // text byte requests
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_text_byte,
  input  logic                                in_last_byte,
  // score requests
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [fss_pkg::OUT_SCORE_W-1:0] out_match_score,
  output logic                                out_matched,
  // configuration writes
  input  logic                                cfg_wr_en,
  input  logic [fss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fss_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // usable query length is bounded by the parameter and by the 16 stored slots
  localparam int QLIM = (MAX_QUERY < fss_pkg::QUERY_SLOTS) ? MAX_QUERY : fss_pkg::QUERY_SLOTS;

  // configuration registers
  logic [fss_pkg::CFG_DATA_W-1:0] q_low_r, q_high_r;
  logic [4:0]                     q_len_r;

  // input register
  logic       s1_vld_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // match state
  logic [fss_pkg::QPOS_W-1:0]     qpos_r, qpos_nxt;
  logic [fss_pkg::RUN_W-1:0]      run_r, run_nxt;
  logic                           first_r, first_nxt;
  logic [7:0]                     prev_r, prev_nxt;
  logic [fss_pkg::TEXT_POS_W-1:0] tpos_r, tpos_nxt;
  logic [fss_pkg::SCORE_W-1:0]    score_r, score_nxt;

  // result register
  logic                                  out_vld_r;
  logic [fss_pkg::OUT_SCORE_W-1:0]       out_score_r, out_score_nxt;
  logic                                  out_hit_r, out_hit_nxt;

  logic                                  s1_adv;
  logic [4:0]                            qlen;
  logic [fss_pkg::QUERY_SLOTS*8-1:0]     q_all;
  logic [7:0]                            q_char;
  logic                                  active, hit;
  logic [fss_pkg::BONUS_W-1:0]           bonus;
  logic [fss_pkg::SCORE_W:0]             sum;
  logic [fss_pkg::SCORE_W-1:0]           score_upd;
  logic [fss_pkg::TEXT_POS_W-1:0]        half;
  logic [fss_pkg::OUT_SCORE_W-1:0]       final_sum;

  // a final byte waits only while the result register is still full
  assign s1_adv   = s1_vld_r && (!s1_last_r || !out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_low_r  <= '0;
      q_high_r <= '0;
      q_len_r  <= '0;
    end else if (cfg_wr_en) begin
      case (fss_pkg::cfg_reg_t'(cfg_index))
        fss_pkg::REG_QUERY_LOW:  q_low_r  <= cfg_data;
        fss_pkg::REG_QUERY_HIGH: q_high_r <= cfg_data;
        fss_pkg::REG_QUERY_LEN:  q_len_r  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_text_byte;
      s1_last_r <= in_last_byte;
    end
  end

  // clamp the configured length
  always_comb begin
    if (int'(q_len_r) > QLIM) begin
      qlen = 5'(QLIM);
    end else begin
      qlen = q_len_r;
    end
  end

  assign q_all  = {q_high_r, q_low_r};
  assign q_char = q_all[qpos_r[3:0]*8 +: 8];
  assign active = (qlen != '0) && (qpos_r < qlen);
  assign hit    = active && (fss_pkg::fold_case(s1_byte_r) == fss_pkg::fold_case(q_char));

  // bonus for one matched byte
  always_comb begin
    bonus = fss_pkg::BONUS_BASE + {1'b0, run_r, 2'b00};
    if (tpos_r == '0 || fss_pkg::is_separator(prev_r)) begin
      bonus = bonus + fss_pkg::BONUS_SEP;
    end
    if (first_r && tpos_r < fss_pkg::EARLY_LIMIT) begin
      bonus = bonus + fss_pkg::BONUS_EARLY;
    end
  end

  assign sum       = {1'b0, score_r} + {3'b000, bonus};
  assign score_upd = sum[fss_pkg::SCORE_W] ? fss_pkg::SCORE_CAP : sum[fss_pkg::SCORE_W-1:0];

  // state update for the byte in the input register
  always_comb begin
    qpos_nxt  = qpos_r;
    run_nxt   = run_r;
    first_nxt = first_r;
    score_nxt = score_r;
    if (hit) begin
      score_nxt = score_upd;
      if (run_r != fss_pkg::RUN_CAP) begin
        run_nxt = run_r + 1'b1;
      end
      qpos_nxt  = qpos_r + 1'b1;
      first_nxt = 1'b0;
    end else if (active) begin
      run_nxt = '0;
    end
    prev_nxt = s1_byte_r;
    tpos_nxt = (tpos_r == fss_pkg::POS_CAP) ? tpos_r : tpos_r + 1'b1;
  end

  // final score from the updated state
  assign half      = {1'b0, tpos_nxt[fss_pkg::TEXT_POS_W-1:1]};
  assign final_sum = {1'b0, score_nxt} +
                     ((half < fss_pkg::LEN_BONUS) ? {4'b0000, fss_pkg::LEN_BONUS - half} : '0);

  always_comb begin
    if (qlen == '0) begin
      out_score_nxt = fss_pkg::OUT_SCORE_W'(1);
      out_hit_nxt   = 1'b1;
    end else if (qpos_nxt >= qlen) begin
      out_score_nxt = final_sum[fss_pkg::SCORE_W] ? {1'b0, fss_pkg::SCORE_CAP} : final_sum;
      out_hit_nxt   = 1'b1;
    end else begin
      out_score_nxt = '1;
      out_hit_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qpos_r  <= '0;
      run_r   <= '0;
      first_r <= 1'b1;
      prev_r  <= '0;
      tpos_r  <= '0;
      score_r <= '0;
    end else if (s1_adv) begin
      if (s1_last_r) begin
        // text done, back to the start state
        qpos_r  <= '0;
        run_r   <= '0;
        first_r <= 1'b1;
        prev_r  <= '0;
        tpos_r  <= '0;
        score_r <= '0;
      end else begin
        qpos_r  <= qpos_nxt;
        run_r   <= run_nxt;
        first_r <= first_nxt;
        prev_r  <= prev_nxt;
        tpos_r  <= tpos_nxt;
        score_r <= score_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_score_r <= out_score_nxt;
      out_hit_r   <= out_hit_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_match_score = signed'(out_score_r);
  assign out_matched     = out_hit_r;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

  // one text byte request as offered on the input channel
  typedef struct {
    logic [7:0] text_byte;
    logic       last_byte;
  } text_req_t;

  // one score request as it should leave the result channel
  typedef struct {
    logic signed [fss_pkg::OUT_SCORE_W-1:0] score;
    logic                                   matched;
  } score_req_t;

  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7a;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [7:0]             in_text_byte = 8'd0;
  logic                   in_last_byte = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic signed [fss_pkg::OUT_SCORE_W-1:0] out_match_score;
  logic                   out_matched;
  logic                   cfg_wr_en = 1'b0;
  logic [fss_pkg::CFG_IDX_W-1:0]  cfg_index = fss_pkg::REG_QUERY_LOW;
  logic [fss_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  fuzzy_subsequence_scorer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_text_byte    (in_text_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_match_score (out_match_score),
    .out_matched     (out_matched),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  // byte requests waiting to be offered, and scores waiting to come out
  text_req_t  text_bytes_q[$];
  score_req_t score_expect_q[$];
  logic [7:0] text_buf[$];

  // shadow of the query registers as last written
  logic [63:0] shadow_query_low = '0;
  logic [63:0] shadow_query_high = '0;
  logic [4:0]  shadow_query_len = '0;

  // scoring state of the text in flight, at the block's widths
  logic [4:0]  hit_count = '0;
  logic [4:0]  streak = '0;
  logic        no_hit_yet = 1'b1;
  logic [7:0]  prior_byte = '0;
  logic [6:0]  byte_pos = '0;
  logic [9:0]  partial_score = '0;

  // idling rates in percent, and the long receiver hold-off
  int send_idle_pct = 14;
  int recv_idle_pct = 87;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;

  int errors = 0;
  int items_queued = 0;
  int bytes_scored = 0;
  int texts_scored = 0;
  int texts_matched = 0;
  int settings_used = 0;

  text_req_t  next_req;
  score_req_t head_score;

  logic [7:0] path_breaks[4] = '{fss_pkg::CH_SLASH, fss_pkg::CH_UNDER,
                                 fss_pkg::CH_DASH, fss_pkg::CH_DOT};

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (c >= fss_pkg::CH_UP_A && c <= fss_pkg::CH_UP_Z) begin
      return c + 8'd32;
    end
    return c;
  endfunction

  function automatic logic is_path_break(input logic [7:0] c);
    return c == fss_pkg::CH_SLASH || c == fss_pkg::CH_UNDER ||
           c == fss_pkg::CH_DASH || c == fss_pkg::CH_DOT;
  endfunction

  // query length in use: the register clamped to what the block stores
  function automatic int query_in_use();
    int n;
    n = int'(shadow_query_len);
    if (n > fss_pkg::MAX_QUERY_DEF) n = fss_pkg::MAX_QUERY_DEF;
    if (n > fss_pkg::QUERY_SLOTS) n = fss_pkg::QUERY_SLOTS;
    return n;
  endfunction

  function automatic logic [7:0] query_byte(input int idx);
    if (idx < 8) return shadow_query_low[8*idx +: 8];
    return shadow_query_high[8*(idx-8) +: 8];
  endfunction

  // update the match state with one accepted byte; on the final byte
  // queue the score the block should report and start a fresh text
  task automatic track_text_byte(input logic [7:0] b, input logic last);
    int         active;
    int         bonus;
    int         total;
    int         half;
    score_req_t want;
    active = query_in_use();
    if (active != 0 && int'(hit_count) < active) begin
      if (to_lower(b) == to_lower(query_byte(int'(hit_count)))) begin
        bonus = 1;
        if (byte_pos == 0 || is_path_break(prior_byte)) bonus += 8;
        bonus += 4 * int'(streak);
        if (no_hit_yet && byte_pos < 4) bonus += 3;
        total = int'(partial_score) + bonus;
        partial_score = (total > 1023) ? 10'd1023 : total[9:0];
        if (streak != 5'd31) streak = streak + 5'd1;
        hit_count = hit_count + 5'd1;
        no_hit_yet = 1'b0;
      end else begin
        streak = '0;
      end
    end
    prior_byte = b;
    if (byte_pos != 7'd127) byte_pos = byte_pos + 7'd1;
    bytes_scored++;
    if (last) begin
      if (active == 0) begin
        want.score = 11'sd1;
        want.matched = 1'b1;
      end else if (int'(hit_count) >= active) begin
        // shorter texts earn a length bonus, gone at 80 bytes
        half = int'(byte_pos) / 2;
        total = int'(partial_score);
        if (half < 40) total += 40 - half;
        if (total > 1023) total = 1023;
        want.score = total[fss_pkg::OUT_SCORE_W-1:0];
        want.matched = 1'b1;
      end else begin
        want.score = -11'sd1;
        want.matched = 1'b0;
      end
      if (want.matched) texts_matched++;
      texts_scored++;
      score_expect_q.insert(score_expect_q.size(), want);
      hit_count = '0;
      streak = '0;
      no_hit_yet = 1'b1;
      prior_byte = '0;
      byte_pos = '0;
      partial_score = '0;
    end
  endtask

  // driver: offer queued bytes, hold each until accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        track_text_byte(in_text_byte, in_last_byte);
      end
      if (!in_valid || in_ready) begin
        if (text_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = text_bytes_q.pop_front();
          in_valid <= 1'b1;
          in_text_byte <= next_req.text_byte;
          in_last_byte <= next_req.last_byte;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long hold-off of the result side, counted here once asked for
  always @(posedge clk) begin
    if (hold_asked != hold_served) begin
      hold_left <= 300;
      hold_served <= hold_asked;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: take score requests and check them against the oldest expected one
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (score_expect_q.size() == 0) begin
          $error("unexpected score request: match_score %0d matched %0b",
                 out_match_score, out_matched);
          errors++;
        end else begin
          head_score = score_expect_q.pop_front();
          if (out_match_score !== head_score.score) begin
            $error("match_score mismatch: expected %0d, actual %0d",
                   head_score.score, out_match_score);
            errors++;
          end
          if (out_matched !== head_score.matched) begin
            $error("matched mismatch: expected %0b, actual %0b",
                   head_score.matched, out_matched);
            errors++;
          end
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // move the collected text into the request queue, last flag on its final byte
  task automatic flush_text();
    int        k;
    text_req_t req;
    for (k = 0; k < text_buf.size(); k++) begin
      req.text_byte = text_buf[k];
      req.last_byte = (k == text_buf.size() - 1);
      text_bytes_q.insert(text_bytes_q.size(), req);
    end
    items_queued += text_buf.size();
    text_buf.delete();
  endtask

  // append one byte to the text being collected
  task automatic add_text_byte(input logic [7:0] b);
    text_buf.insert(text_buf.size(), b);
  endtask

  task automatic queue_string(input string s);
    int k;
    for (k = 0; k < s.len(); k++) add_text_byte(s[k]);
    flush_text();
  endtask

  // mostly letters, some capitals and path separators, a few arbitrary bytes
  function automatic logic [7:0] random_char();
    int roll;
    roll = $urandom_range(9);
    if (roll < 6) return CH_LOW_A + 8'($urandom_range(25));
    if (roll < 8) return fss_pkg::CH_UP_A + 8'($urandom_range(25));
    if (roll == 8) return path_breaks[2'($urandom_range(3))];
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    if ($urandom_range(1) == 0) return c;
    if (c >= fss_pkg::CH_UP_A && c <= fss_pkg::CH_UP_Z) return c + 8'd32;
    if (c >= CH_LOW_A && c <= CH_LOW_Z) return c - 8'd32;
    return c;
  endfunction

  // a text that carries the query in order with noise between its characters;
  // with drop_one set one query character is left out
  task automatic queue_query_text(input bit drop_one, input int lead);
    int active;
    int skip;
    int i;
    active = query_in_use();
    skip = (drop_one && active > 0) ? int'($urandom_range(active - 1)) : -1;
    repeat (lead) add_text_byte(random_char());
    for (i = 0; i < active; i++) begin
      repeat ($urandom_range(2)) add_text_byte(random_char());
      if (i != skip) add_text_byte(flip_case(query_byte(i)));
    end
    repeat ($urandom_range(2)) add_text_byte(random_char());
    if (text_buf.size() == 0) add_text_byte(random_char());
    flush_text();
  endtask

  task automatic load_query(input logic [63:0] low, input logic [63:0] high,
                            input logic [4:0] len);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= fss_pkg::REG_QUERY_LOW;
    cfg_data <= low;
    @(posedge clk);
    cfg_index <= fss_pkg::REG_QUERY_HIGH;
    cfg_data <= high;
    @(posedge clk);
    cfg_index <= fss_pkg::REG_QUERY_LEN;
    cfg_data <= {{(fss_pkg::CFG_DATA_W-5){1'b0}}, len};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_query_low = low;
    shadow_query_high = high;
    shadow_query_len = len;
    settings_used++;
  endtask

  task automatic load_random_query(input logic [4:0] len);
    logic [63:0] low;
    logic [63:0] high;
    int i;
    for (i = 0; i < 8; i++) begin
      low[8*i +: 8] = random_char();
      high[8*i +: 8] = random_char();
    end
    load_query(low, high, len);
  endtask

  // sender quiet until every score is back, then let the pipeline settle
  task automatic wait_all_scored();
    while (text_bytes_q.size() != 0 || in_valid || score_expect_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic run_random_phase(input int budget);
    int start;
    int roll;
    start = items_queued;
    while (items_queued - start < budget) begin
      roll = $urandom_range(99);
      if (roll < 70) begin
        queue_query_text(1'b0, 0);
      end else if (roll < 85) begin
        queue_query_text(1'b1, 0);
      end else begin
        repeat ($urandom_range(1, 8)) add_text_byte(8'($urandom_range(255)));
        flush_text();
      end
    end
    wait_all_scored();
  endtask

  initial begin
    int phase;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty query after reset: every text scores 1, extreme byte values
    add_text_byte(8'h00);
    flush_text();
    add_text_byte(8'hff);
    flush_text();
    wait_all_scored();

    // query "Ab": case folding, separators, early bonus edge, misses, extra bytes
    load_query(64'h0000_0000_0000_6241, 64'h0, 5'd2);
    queue_string("ab");
    queue_string("x_AB");
    queue_string("-a.b");
    queue_string("zzz");
    queue_string("abab");
    queue_string("xxxaxb");
    queue_string("xxxxab");
    wait_all_scored();

    for (phase = 0; phase < 6; phase++) begin
      if (phase == 2) begin
        send_idle_pct <= 87;
        recv_idle_pct <= 14;
      end
      if (phase == 4) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      case (phase)
        0: load_random_query(5'd16);
        1: load_query('1, '1, 5'd31);      // oversized length, all-ones characters
        2: load_random_query(5'd0);
        3: load_random_query(5'd1);
        4: load_query('0, '0, 5'd3);       // query of nul bytes
        default: load_random_query(5'($urandom_range(2, 15)));
      endcase
      // long texts can run the position counter into saturation
      if (phase == 0 || phase == 5) queue_query_text(1'b0, $urandom_range(85, 140));
      // result side holds off while the sender keeps offering
      if (phase == 5) hold_asked <= hold_asked + 1;
      run_random_phase(40);
    end

    $display("covered %0d text bytes in %0d texts (%0d matched, %0d not) under %0d queries",
             bytes_scored, texts_scored, texts_matched, texts_scored - texts_matched,
             settings_used);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
